@@ sv/extent_list_offset_translator_macros.svh @@
// Assertion macros used by the checker file of the offset translator.
`ifndef EXTENT_LIST_OFFSET_TRANSLATOR_MACROS_SVH
`define EXTENT_LIST_OFFSET_TRANSLATOR_MACROS_SVH

// Checked only while the block is out of reset.
`define ELOT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ELOT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/elot_pkg.sv @@
// Types, constants and codes shared by the offset translator modules.
package elot_pkg;

    localparam int MAX_EXTENTS = 16;
    localparam int ADDR_W      = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int IDX_W       = $clog2(MAX_EXTENTS + 1);
    localparam int PADDR_W     = 4;

    localparam logic       KIND_LOAD = 1'b0;
    localparam logic       KIND_READ = 1'b1;
    localparam logic       MODE_SINGLE = 1'b0;
    localparam logic       MODE_EXTENT = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

    localparam logic [1:0] REG_SOURCE_MODE  = 2'd0;
    localparam logic [1:0] REG_SINGLE_BASE  = 2'd1;
    localparam logic [1:0] REG_TOTAL_LENGTH = 2'd2;
    localparam logic [1:0] REG_NUM_EXTENTS  = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [3:0]  entry_index;
        logic [31:0] extent_base;
        logic [31:0] extent_size;
        logic [31:0] read_offset;
        logic [31:0] read_count;
    } req_item_t;

    typedef struct packed {
        logic [31:0] seg_address;
        logic [31:0] seg_length;
        logic [1:0]  status;
        logic        last;
    } seg_item_t;

    typedef struct packed {
        logic        source_mode;
        logic [31:0] single_base;
        logic [31:0] total_length;
        logic [4:0]  num_extents;
    } cfg_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       base;
        logic [31:0]       length;
    } tbl_wr_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic        carry;
        logic [31:0] sum;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOUND,
        ST_SINGLE,
        ST_SEEK,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_SPLIT_RD,
        ST_SPLIT,
        ST_CLIP,
        ST_EMIT,
        ST_ADV_OFF,
        ST_ADV_CNT,
        ST_ADV_START
    } state_t;

endpackage

@@ sv/elot_regs.sv @@
// Configuration register file behind the APB-style port.
module elot_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [elot_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output elot_pkg::cfg_t               cfg,
    output logic                         cfg_write
);
    import elot_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_idx;
    logic       wr;

    assign reg_idx   = paddr[PADDR_W-1:2];
    assign wr        = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;
    assign cfg_write = wr;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (reg_idx)
                REG_SOURCE_MODE:  cfg_next.source_mode  = pwdata[0];
                REG_SINGLE_BASE:  cfg_next.single_base  = pwdata;
                REG_TOTAL_LENGTH: cfg_next.total_length = pwdata;
                REG_NUM_EXTENTS:  cfg_next.num_extents  = pwdata[4:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_SOURCE_MODE:  prdata = {31'd0, cfg_reg.source_mode};
            REG_SINGLE_BASE:  prdata = cfg_reg.single_base;
            REG_TOTAL_LENGTH: prdata = cfg_reg.total_length;
            REG_NUM_EXTENTS:  prdata = {27'd0, cfg_reg.num_extents};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

@@ sv/elot_table.sv @@
// Extent table memory: base and length per slot, one write and one registered read.
module elot_table (
    input  logic                        clk,
    input  elot_pkg::tbl_wr_t           wr,
    input  logic [elot_pkg::ADDR_W-1:0] rd_addr,
    output logic [31:0]                 rd_base,
    output logic [31:0]                 rd_len
);
    import elot_pkg::*;

    logic [31:0] base_mem [MAX_EXTENTS];
    logic [31:0] len_mem  [MAX_EXTENTS];
    logic [31:0] rd_base_reg;
    logic [31:0] rd_len_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            base_mem[wr.addr] <= wr.base;
            len_mem[wr.addr]  <= wr.length;
        end
        rd_base_reg <= base_mem[rd_addr];
        rd_len_reg  <= len_mem[rd_addr];
    end

    assign rd_base = rd_base_reg;
    assign rd_len  = rd_len_reg;

endmodule

@@ sv/elot_alu.sv @@
// Shared 32-bit adder/subtractor with carry out, used by the arithmetic steps of the sequencer.
module elot_alu (
    input  elot_pkg::alu_req_t req,
    output elot_pkg::alu_rsp_t rsp
);
    import elot_pkg::*;

    logic [31:0] b_in;
    logic        cin;
    logic [32:0] total;

    assign b_in  = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign cin   = (req.op == ALU_SUB);
    assign total = {1'b0, req.a} + {1'b0, b_in} + {32'd0, cin};

    // For a subtraction the carry out is high when no borrow occurred.
    assign rsp.carry = total[32];
    assign rsp.sum   = total[31:0];

endmodule

@@ sv/elot_seq.sv @@
// Request sequencer: bounds check, extent walk, segment split, cursor and result register.
module elot_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  elot_pkg::req_item_t         req_item,
    output logic                        seg_valid,
    input  logic                        seg_ready,
    output elot_pkg::seg_item_t         seg_item,
    input  elot_pkg::cfg_t              cfg,
    input  logic                        cfg_write,
    output elot_pkg::tbl_wr_t           tbl_wr,
    output logic [elot_pkg::ADDR_W-1:0] rd_addr,
    input  logic [31:0]                 rd_base,
    input  logic [31:0]                 rd_len,
    output elot_pkg::alu_req_t          alu_req,
    input  elot_pkg::alu_rsp_t          alu_rsp
);
    import elot_pkg::*;

    state_t           state_reg, state_next;
    logic [31:0]      off_reg, off_next;
    logic [31:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      start_reg, start_next;
    logic [31:0]      within_reg, within_next;
    logic [31:0]      n_reg, n_next;
    logic [IDX_W-1:0] cur_idx_reg;
    logic [31:0]      cur_start_reg;
    logic             out_valid_reg;
    seg_item_t        out_data_reg;

    logic             emit_ok;
    logic             emit;
    seg_item_t        emit_data;
    logic             cursor_upd;
    logic [IDX_W-1:0] n_ext;
    logic [32:0]      sum33;

    assign emit_ok   = !out_valid_reg || seg_ready;
    assign seg_valid = out_valid_reg;
    assign seg_item  = out_data_reg;
    assign rd_addr   = idx_reg[ADDR_W-1:0];
    assign sum33     = {alu_rsp.carry, alu_rsp.sum};

    always_comb
    begin
        if (32'(cfg.num_extents) > 32'(MAX_EXTENTS))
        begin
            n_ext = IDX_W'(MAX_EXTENTS);
        end
        else
        begin
            n_ext = IDX_W'(cfg.num_extents);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        off_next    = off_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        start_next  = start_reg;
        within_next = within_reg;
        n_next      = n_reg;
        emit        = 1'b0;
        emit_data   = '{seg_address: 32'd0, seg_length: 32'd0,
                        status: STATUS_OK, last: 1'b1};
        cursor_upd  = 1'b0;
        req_ready   = 1'b0;
        alu_req     = '{op: ALU_ADD, a: off_reg, b: cnt_reg};
        tbl_wr      = '{en: 1'b0, addr: ADDR_W'(req_item.entry_index),
                        base: req_item.extent_base, length: req_item.extent_size};

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_item.kind == KIND_LOAD)
                    begin
                        // Slots beyond the table are dropped.
                        tbl_wr.en = (32'(req_item.entry_index) < 32'(MAX_EXTENTS));
                    end
                    else
                    begin
                        off_next   = req_item.read_offset;
                        cnt_next   = req_item.read_count;
                        state_next = ST_BOUND;
                    end
                end
            end

            ST_BOUND:
            begin
                alu_req = '{op: ALU_ADD, a: off_reg, b: cnt_reg};
                if (sum33 > {1'b0, cfg.total_length})
                begin
                    if (emit_ok)
                    begin
                        emit             = 1'b1;
                        emit_data.status = STATUS_RANGE;
                        state_next       = ST_IDLE;
                    end
                end
                else if (cfg.source_mode == MODE_SINGLE)
                begin
                    state_next = ST_SINGLE;
                end
                else
                begin
                    state_next = ST_SEEK;
                end
            end

            ST_SINGLE:
            begin
                alu_req = '{op: ALU_ADD, a: cfg.single_base, b: off_reg};
                if (emit_ok)
                begin
                    emit                  = 1'b1;
                    emit_data.seg_address = (cnt_reg == 32'd0) ? 32'd0 : alu_rsp.sum;
                    emit_data.seg_length  = cnt_reg;
                    state_next            = ST_IDLE;
                end
            end

            ST_SEEK:
            begin
                // A backward seek restarts the walk at the first extent.
                alu_req = '{op: ALU_SUB, a: off_reg, b: cur_start_reg};
                if (!alu_rsp.carry)
                begin
                    idx_next   = '0;
                    start_next = 32'd0;
                end
                else
                begin
                    idx_next   = cur_idx_reg;
                    start_next = cur_start_reg;
                end
                state_next = ST_FIND_RD;
            end

            ST_FIND_RD:
            begin
                if (idx_reg >= n_ext)
                begin
                    state_next = ST_SPLIT;
                end
                else
                begin
                    state_next = ST_FIND_CMP;
                end
            end

            ST_FIND_CMP:
            begin
                alu_req = '{op: ALU_ADD, a: start_reg, b: rd_len};
                if ({1'b0, off_reg} < sum33)
                begin
                    state_next = ST_SPLIT;
                end
                else
                begin
                    start_next = alu_rsp.sum;
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_FIND_RD;
                end
            end

            ST_SPLIT_RD:
            begin
                state_next = ST_SPLIT;
            end

            ST_SPLIT:
            begin
                alu_req = '{op: ALU_SUB, a: off_reg, b: start_reg};
                if (cnt_reg == 32'd0)
                begin
                    if (emit_ok)
                    begin
                        emit       = 1'b1;
                        cursor_upd = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (idx_reg >= n_ext)
                begin
                    if (emit_ok)
                    begin
                        emit             = 1'b1;
                        emit_data.status = STATUS_EXHAUSTED;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    within_next = alu_rsp.sum;
                    state_next  = ST_CLIP;
                end
            end

            ST_CLIP:
            begin
                alu_req    = '{op: ALU_SUB, a: rd_len, b: within_reg};
                n_next     = (alu_rsp.sum > cnt_reg) ? cnt_reg : alu_rsp.sum;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                alu_req = '{op: ALU_ADD, a: rd_base, b: within_reg};
                if (emit_ok)
                begin
                    emit                  = 1'b1;
                    emit_data.seg_address = alu_rsp.sum;
                    emit_data.seg_length  = n_reg;
                    emit_data.last        = (n_reg == cnt_reg);
                    if (n_reg == cnt_reg)
                    begin
                        cursor_upd = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ADV_OFF;
                    end
                end
            end

            ST_ADV_OFF:
            begin
                alu_req    = '{op: ALU_ADD, a: off_reg, b: n_reg};
                off_next   = alu_rsp.sum;
                state_next = ST_ADV_CNT;
            end

            ST_ADV_CNT:
            begin
                alu_req    = '{op: ALU_SUB, a: cnt_reg, b: n_reg};
                cnt_next   = alu_rsp.sum;
                state_next = ST_ADV_START;
            end

            ST_ADV_START:
            begin
                alu_req    = '{op: ALU_ADD, a: start_reg, b: rd_len};
                start_next = alu_rsp.sum;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = ST_SPLIT_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            cur_start_reg <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (seg_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                cur_idx_reg   <= '0;
                cur_start_reg <= 32'd0;
            end
            else if (cursor_upd)
            begin
                cur_idx_reg   <= idx_reg;
                cur_start_reg <= start_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        start_reg  <= start_next;
        within_reg <= within_next;
        n_reg      <= n_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
        end
    end

endmodule

@@ sv/extent_list_offset_translator.sv @@
// Extent list offset translator: turns logical read requests into physical segments.
//
// A load request writes one slot of the 16-entry extent table in the cycle it is
// accepted and gives no result. A read request is checked against total_length and
// then, in single mode, becomes one segment; in extent mode the block resumes from
// its cached cursor (or from the first extent on a backward seek), walks to the
// extent holding the offset and emits one segment per extent touched. All address
// and length arithmetic goes through one shared 32-bit adder, one operation per
// cycle, and each table lookup costs a registered read. A step that emits a result
// waits while the consumer stalls the result register. The block accepts no request
// while a read is in progress; a result already waiting does not keep it from taking
// the next request. The cursor is cleared by any configuration write.
module extent_list_offset_translator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  elot_pkg::req_item_t          req_item,
    output logic                         seg_valid,
    input  logic                         seg_ready,
    output elot_pkg::seg_item_t          seg_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [elot_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import elot_pkg::*;

    cfg_t              cfg;
    logic              cfg_write;
    tbl_wr_t           tbl_wr;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_base;
    logic [31:0]       rd_len;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    elot_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .cfg_write (cfg_write)
    );

    elot_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_base (rd_base),
        .rd_len  (rd_len)
    );

    elot_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    elot_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_item  (seg_item),
        .cfg       (cfg),
        .cfg_write (cfg_write),
        .tbl_wr    (tbl_wr),
        .rd_addr   (rd_addr),
        .rd_base   (rd_base),
        .rd_len    (rd_len),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp)
    );

endmodule

@@ sv/elot_checker.sv @@
// Port-level checker for the offset translator and its bind to the top level.
`include "extent_list_offset_translator_macros.svh"

module elot_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input elot_pkg::req_item_t req_item,
    input logic                seg_valid,
    input logic                seg_ready,
    input elot_pkg::seg_item_t seg_item
);
    import elot_pkg::*;

    // A result that the consumer has not taken must hold.
    `ELOT_ASSERT(a_seg_hold, seg_valid && !seg_ready |=> seg_valid && $stable(seg_item), "result changed while stalled")

    // Error results carry no segment and always end the request.
    `ELOT_ASSERT(a_err_last, seg_valid && seg_item.status != STATUS_OK |-> seg_item.last && seg_item.seg_address == 32'd0 && seg_item.seg_length == 32'd0, "error result malformed")

    // A table load never occupies the sequencer.
    `ELOT_ASSERT(a_load_ready, req_valid && req_ready && req_item.kind == KIND_LOAD |=> req_ready, "busy after a table load")

    // A read request keeps the block busy for at least the bounds check.
    `ELOT_ASSERT(a_read_busy, req_valid && req_ready && req_item.kind == KIND_READ |=> !req_ready, "ready right after a read request")

    // A clock edge seen in reset leaves the result register empty.
    `ELOT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !seg_valid, "result shown after a reset edge")

endmodule

bind extent_list_offset_translator elot_checker u_elot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .seg_item  (seg_item)
);
